### design/unsigned_to_radix_ascii_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix ASCII converter
// Concurrent assertion shorthands, clocked and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_RADIX_ASCII_ASSERT_SVH
`define UNSIGNED_TO_RADIX_ASCII_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define U2RA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define U2RA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define U2RA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/u2ra_pkg.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter package
// Shared widths, the queue word type, the back end states and the digit map.
// ----------------------------------------------------------------------------
package u2ra_pkg;

    localparam int WORD_W          = 32;
    localparam int RADIX_W         = 8;
    localparam int DIGIT_W         = 6;
    localparam int CHAR_W          = 8;
    localparam int COUNT_OUT_W     = 6;
    localparam int MAX_DIGITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int STEPS_PER_CYCLE = 8;
    localparam int DIV_CYCLES      = WORD_W / STEPS_PER_CYCLE;
    localparam int STEP_W          = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 8'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd16;
    localparam logic [DIGIT_W-1:0] NUM_DIGITS  = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_LETTER = 8'h37;
    localparam logic [CHAR_W-1:0]  CHAR_NUL    = 8'h00;

    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [DIGIT_W-1:0] radix;
        logic               err;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LOAD,
        ST_LAST
    } t_back_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] m;
        m = (d >= NUM_DIGITS) ? d - NUM_DIGITS : d;
        if (m < DEC_DIGITS) begin
            return CHAR_ZERO + CHAR_W'(m);
        end else begin
            return CHAR_LETTER + CHAR_W'(m);
        end
    endfunction

endpackage

### design/u2ra_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module u2ra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/u2ra_front.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter front end
// Holds the radix register, accepts input words and classifies them by radix.
// ----------------------------------------------------------------------------
module u2ra_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [u2ra_pkg::RADIX_W-1:0] i_cfg_radix,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [u2ra_pkg::WORD_W-1:0]  i_value_in,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output u2ra_pkg::t_job               o_q_job
);

    import u2ra_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic               bad_radix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_radix;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign bad_radix     = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);
    assign o_in_ready    = !i_q_full;
    assign o_q_push      = i_in_valid && !i_q_full;
    assign o_q_job.value = i_value_in;
    assign o_q_job.radix = r_radix[DIGIT_W-1:0];
    assign o_q_job.err   = bad_radix;

endmodule

### design/u2ra_queue.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter job queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "unsigned_to_radix_ascii_assert.svh"

module u2ra_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  u2ra_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output u2ra_pkg::t_job o_job
);

    import u2ra_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];
    assign n_wptr  = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr  = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    `U2RA_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue overfilled")
    `U2RA_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `U2RA_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop && o_empty, !o_empty,
        "pushed word lost")

endmodule

### design/u2ra_back.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter back end
// Divides each good job by its radix into the digit store, then emits the digits and a terminator.
// ----------------------------------------------------------------------------
`include "unsigned_to_radix_ascii_assert.svh"

module u2ra_back #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  u2ra_pkg::t_job                   i_q_job,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [u2ra_pkg::CHAR_W-1:0]      o_char_code,
    output logic                             o_is_last,
    output logic                             o_base_error,
    output logic [u2ra_pkg::COUNT_OUT_W-1:0] o_digit_count
);

    import u2ra_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    t_back_state       r_state, n_state;
    logic [WORD_W-1:0]  r_quo, n_quo;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [DIGIT_W-1:0] r_radix, n_radix;
    logic               r_err, n_err;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    logic               r_berr, n_berr;
    logic [CW-1:0]      r_ocnt, n_ocnt;

    logic [WORD_W-1:0]  div_quo;
    logic [DIGIT_W-1:0] div_rem;
    logic [DIGIT_W:0]   trial;
    logic [CW-1:0]      cnt_inc;
    logic               slot_free;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [DIGIT_W-1:0] ram_rdata;

    always_comb begin
        div_quo = r_quo;
        div_rem = r_rem;
        trial   = '0;
        for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
            trial   = {div_rem, div_quo[WORD_W-1]};
            div_quo = {div_quo[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_radix}) begin
                trial      = trial - {1'b0, r_radix};
                div_quo[0] = 1'b1;
            end
            div_rem = trial[DIGIT_W-1:0];
        end
    end

    assign cnt_inc   = r_cnt + 1'b1;
    assign slot_free = !r_out_valid || i_out_ready;
    assign ram_raddr = AW'(r_idx - 1'b1);

    u2ra_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (div_rem),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_err       = r_err;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        n_berr      = r_berr;
        n_ocnt      = r_ocnt;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_quo   = i_q_job.value;
                    n_radix = i_q_job.radix;
                    n_err   = i_q_job.err;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = i_q_job.err ? ST_LAST : ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo  = div_quo;
                n_rem  = div_rem;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_CYCLES - 1)) begin
                    ram_we = 1'b1;
                    n_cnt  = cnt_inc;
                    n_rem  = '0;
                    if (div_quo == '0 || cnt_inc == CW'(MAX_DIGITS)) begin
                        n_idx   = cnt_inc;
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                ram_re  = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_char(ram_rdata);
                    n_last      = 1'b0;
                    n_berr      = 1'b0;
                    n_ocnt      = '0;
                    n_idx       = r_idx - 1'b1;
                    n_state     = (r_idx == CW'(1)) ? ST_LAST : ST_RD;
                end
            end
            ST_LAST: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_NUL;
                    n_last      = 1'b1;
                    n_berr      = r_err;
                    n_ocnt      = r_err ? '0 : r_cnt;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_err   <= n_err;
        r_step  <= n_step;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_char  <= n_char;
        r_last  <= n_last;
        r_berr  <= n_berr;
        r_ocnt  <= n_ocnt;
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_code   = r_char;
    assign o_is_last     = r_last;
    assign o_base_error  = r_berr;
    assign o_digit_count = COUNT_OUT_W'(r_ocnt);

    `U2RA_ASSERT_IMP(a_rem_below_radix, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_radix,
        "partial remainder not below radix")
    `U2RA_ASSERT_IMP(a_digit_word, i_clk, i_rst_n, r_out_valid && !r_last,
        r_char != CHAR_NUL && r_ocnt == '0 && !r_berr, "digit word carries terminator fields")
    `U2RA_ASSERT_IMP(a_error_count, i_clk, i_rst_n, r_out_valid && r_berr,
        r_last && r_ocnt == '0, "error flagged off an empty terminator")

endmodule

### design/unsigned_to_radix_ascii.sv
// The divider takes 8 quotient bits a cycle and the digit store has one read port.
// A word with a bad radix skips the divider. Words queue while the back end is busy.
// Reset, synchronous and active low, clears the queue, the control state and
// sets the radix to 16; the digit store is not cleared.
// ----------------------------------------------------------------------------
// Unsigned to radix ASCII converter
// Converts 32-bit unsigned words to upper-case digit text with a NUL terminator.
// ----------------------------------------------------------------------------
module unsigned_to_radix_ascii #(
    parameter int MAX_DIGITS  = u2ra_pkg::MAX_DIGITS_DEF,
    parameter int QUEUE_DEPTH = u2ra_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [u2ra_pkg::RADIX_W-1:0]     i_cfg_radix,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [u2ra_pkg::WORD_W-1:0]      i_value_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [u2ra_pkg::CHAR_W-1:0]      o_char_code,
    output logic                             o_is_last,
    output logic                             o_base_error,
    output logic [u2ra_pkg::COUNT_OUT_W-1:0] o_digit_count
);

    import u2ra_pkg::*;

    logic q_full;
    logic q_push;
    logic q_empty;
    logic q_pop;
    t_job push_job;
    t_job head_job;

    u2ra_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_radix (i_cfg_radix),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value_in  (i_value_in),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (push_job)
    );

    u2ra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    u2ra_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_job       (head_job),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_code   (o_char_code),
        .o_is_last     (o_is_last),
        .o_base_error  (o_base_error),
        .o_digit_count (o_digit_count)
    );

endmodule
